// ===== rtl/core/fss_pkg.sv =====
// Shared types, widths and constants for the Fourier series synthesizer.
package fss_pkg;

    localparam int HARMONICS   = 4;
    localparam int TIME_W      = 32;
    localparam int FREQ_W      = 32;
    localparam int LANE_W      = 16;
    localparam int TABLE_W     = HARMONICS * LANE_W;
    localparam int COUNT_W     = 3;
    localparam int RESULT_W    = 19;
    localparam int MAG_W       = 15;
    localparam int COS_W       = 16;
    localparam int TERM_W      = 32;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Register reset values.
    localparam logic [FREQ_W-1:0]  FREQ_RESET  = 32'd65536;
    localparam logic [TABLE_W-1:0] AMP_RESET   = 64'd4096;
    localparam logic [TABLE_W-1:0] PHASE_RESET = 64'd0;
    localparam logic [COUNT_W-1:0] COUNT_RESET = 3'd1;

    // Odd polynomial for sin(pi/2 * x), coefficients in unsigned Q.30.
    localparam logic [30:0] POLY_A = 31'd1686629713;
    localparam logic [29:0] POLY_B = 30'd693598668;
    localparam logic [26:0] POLY_C = 27'd85569306;
    localparam logic [22:0] POLY_D = 23'd5026995;
    localparam logic [17:0] POLY_E = 18'd172272;

    // Quarter turn in phase units, and the saturation limit of the cosine.
    localparam logic [MAG_W-1:0] QUARTER_TURN = 15'd16384;
    localparam logic [17:0]      COS_MAX      = 18'd32767;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FREQUENCY = 3'd0,
        CFG_AMPLITUDE = 3'd1,
        CFG_PHASE     = 3'd2,
        CFG_COUNT     = 3'd3
    } cfg_index_t;

    typedef struct packed {
        logic [FREQ_W-1:0]  frequency;
        logic [TABLE_W-1:0] amplitude;
        logic [TABLE_W-1:0] phase;
        logic [COUNT_W-1:0] count;
    } cfg_t;

    typedef logic [MAG_W-1:0]        mag_t;
    typedef logic signed [COS_W-1:0] cos_t;

endpackage

// ===== rtl/core/fss_phase.sv =====
// Phase stages: time times frequency, per-harmonic phase and quadrant fold.
module fss_phase import fss_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  cfg_t              cfg,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [TIME_W-1:0] in_time,
    output logic              out_valid,
    input  logic              out_ready,
    output mag_t              out_mag [HARMONICS],
    output logic              out_neg [HARMONICS]
);

    logic              v1_reg, v2_reg;
    logic              adv1, adv2;
    logic [31:0]       prod_reg;
    mag_t              mag_reg [HARMONICS];
    logic              neg_reg [HARMONICS];

    logic [34:0]       mult [HARMONICS];
    logic [32:0]       rnd  [HARMONICS];
    logic [15:0]       ph   [HARMONICS];
    mag_t              mag_next [HARMONICS];
    logic              neg_next [HARMONICS];

    assign adv2     = ~v2_reg | out_ready;
    assign adv1     = ~v1_reg | adv2;
    assign in_ready = adv1;

    // Only the fraction of a turn matters, so the low word of the product is kept.
    always_comb begin
        for (int k = 0; k < HARMONICS; k++) begin
            mult[k] = 35'(prod_reg) * 35'(k + 1);
            rnd[k]  = 33'(mult[k][31:0]) + 33'(32768);
            ph[k]   = rnd[k][31:16] + cfg.phase[LANE_W*k +: LANE_W];
            if (ph[k][14]) begin
                mag_next[k] = {1'b0, ph[k][13:0]};
            end else begin
                mag_next[k] = QUARTER_TURN - {1'b0, ph[k][13:0]};
            end
            neg_next[k] = ph[k][15] ^ ph[k][14];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv1) begin
            prod_reg <= 32'(64'(cfg.frequency) * 64'(in_time));
        end
        if (adv2) begin
            for (int k = 0; k < HARMONICS; k++) begin
                mag_reg[k] <= mag_next[k];
                neg_reg[k] <= neg_next[k];
            end
        end
    end

    assign out_valid = v2_reg;
    assign out_mag   = mag_reg;
    assign out_neg   = neg_reg;

endmodule

// ===== rtl/core/fss_cosine.sv =====
// Cosine stages: squaring, then the quarter-wave polynomial by Horner steps, one per stage, then rounding and sign.
module fss_cosine import fss_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  mag_t in_mag [HARMONICS],
    input  logic in_neg [HARMONICS],
    output logic out_valid,
    input  logic out_ready,
    output cos_t out_cos [HARMONICS]
);

    localparam int STAGES = 7;

    logic        v_reg [STAGES];
    logic        adv   [STAGES];

    mag_t        m_reg   [STAGES-1][HARMONICS];
    logic        neg_reg [STAGES-1][HARMONICS];
    logic [30:0] x2_reg  [4][HARMONICS];
    logic [22:0] t1_reg  [HARMONICS];
    logic [26:0] t2_reg  [HARMONICS];
    logic [29:0] t3_reg  [HARMONICS];
    logic [30:0] t4_reg  [HARMONICS];
    logic [31:0] s_reg   [HARMONICS];
    cos_t        cos_reg [HARMONICS];

    logic [29:0] sq [HARMONICS];
    logic [48:0] p1 [HARMONICS];
    logic [53:0] p2 [HARMONICS];
    logic [57:0] p3 [HARMONICS];
    logic [60:0] p4 [HARMONICS];
    logic [45:0] p5 [HARMONICS];
    logic [32:0] rq [HARMONICS];
    logic [17:0] q15 [HARMONICS];
    logic [15:0] mag15 [HARMONICS];

    // The advance chain is built from the output end, so each stage sees the
    // final value of the stage after it.
    always_comb begin
        adv[STAGES-1] = ~v_reg[STAGES-1] | out_ready;
        for (int i = STAGES - 2; i >= 0; i--) begin
            adv[i] = ~v_reg[i] | adv[i+1];
        end
    end

    assign in_ready = adv[0];

    // x is m in Q.30 shifted up by 16, so x*x>>30 is m*m*4 and x*t>>30 is m*t>>14.
    always_comb begin
        for (int k = 0; k < HARMONICS; k++) begin
            sq[k]  = 30'(in_mag[k]) * 30'(in_mag[k]);
            p1[k]  = 49'(x2_reg[0][k]) * 49'(POLY_E);
            p2[k]  = 54'(x2_reg[1][k]) * 54'(t1_reg[k]);
            p3[k]  = 58'(x2_reg[2][k]) * 58'(t2_reg[k]);
            p4[k]  = 61'(x2_reg[3][k]) * 61'(t3_reg[k]);
            p5[k]  = 46'(m_reg[4][k]) * 46'(t4_reg[k]);
            rq[k]  = 33'(s_reg[k]) + 33'(16384);
            q15[k] = rq[k][32:15];
            if (q15[k] > COS_MAX) begin
                mag15[k] = 16'(COS_MAX);
            end else begin
                mag15[k] = q15[k][15:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STAGES; i++) begin
                v_reg[i] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++) begin
                if (adv[i]) begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int k = 0; k < HARMONICS; k++) begin
            if (adv[0]) begin
                m_reg[0][k]   <= in_mag[k];
                neg_reg[0][k] <= in_neg[k];
                x2_reg[0][k]  <= {sq[k][28:0], 2'b00};
            end
            for (int i = 1; i < STAGES - 1; i++) begin
                if (adv[i]) begin
                    m_reg[i][k]   <= m_reg[i-1][k];
                    neg_reg[i][k] <= neg_reg[i-1][k];
                end
            end
            for (int i = 1; i < 4; i++) begin
                if (adv[i]) begin
                    x2_reg[i][k] <= x2_reg[i-1][k];
                end
            end
            if (adv[1]) begin
                t1_reg[k] <= POLY_D - 23'(p1[k] >> 30);
            end
            if (adv[2]) begin
                t2_reg[k] <= POLY_C - 27'(p2[k] >> 30);
            end
            if (adv[3]) begin
                t3_reg[k] <= POLY_B - 30'(p3[k] >> 30);
            end
            if (adv[4]) begin
                t4_reg[k] <= POLY_A - 31'(p4[k] >> 30);
            end
            if (adv[5]) begin
                s_reg[k] <= 32'(p5[k] >> 14);
            end
            if (adv[6]) begin
                if (neg_reg[5][k]) begin
                    cos_reg[k] <= -$signed(mag15[k]);
                end else begin
                    cos_reg[k] <= $signed(mag15[k]);
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES-1];
    assign out_cos   = cos_reg;

endmodule

// ===== rtl/core/fss_accum.sv =====
// Output stages: amplitude products, sum over harmonics and rounding to Q.12.
module fss_accum import fss_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  cfg_t                       cfg,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  cos_t                       in_cos [HARMONICS],
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [RESULT_W-1:0] out_value
);

    localparam int SUM_W = TERM_W + 2;

    logic                       v1_reg, v2_reg;
    logic                       adv1, adv2;
    logic signed [TERM_W-1:0]   term_reg [HARMONICS];
    logic signed [RESULT_W-1:0] value_reg;

    logic signed [LANE_W-1:0]   amp [HARMONICS];
    logic signed [SUM_W-1:0]    sum_next;
    logic signed [SUM_W-1:0]    shifted;

    assign adv2     = ~v2_reg | out_ready;
    assign adv1     = ~v1_reg | adv2;
    assign in_ready = adv1;

    always_comb begin
        for (int k = 0; k < HARMONICS; k++) begin
            amp[k] = $signed(cfg.amplitude[LANE_W*k +: LANE_W]);
        end
        sum_next = SUM_W'(16384);
        for (int k = 0; k < HARMONICS; k++) begin
            sum_next = sum_next + SUM_W'(term_reg[k]);
        end
        shifted = sum_next >>> 15;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (adv1) begin
                v1_reg <= in_valid;
            end
            if (adv2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    // A lane beyond the harmonic count contributes zero; counts above four saturate.
    always_ff @(posedge aclk) begin
        if (adv1) begin
            for (int k = 0; k < HARMONICS; k++) begin
                if (cfg.count > COUNT_W'(k)) begin
                    term_reg[k] <= TERM_W'(amp[k]) * TERM_W'(in_cos[k]);
                end else begin
                    term_reg[k] <= '0;
                end
            end
        end
        if (adv2) begin
            value_reg <= shifted[RESULT_W-1:0];
        end
    end

    assign out_valid = v2_reg;
    assign out_value = value_reg;

endmodule

// ===== rtl/core/fourier_series_synthesizer_top.sv =====
// Top level of the Fourier series synthesizer: configuration registers and pipeline.
//
// Usage: each word on the s_ channel is a time sample (unsigned Q16.16). For each
// one the block returns one word on the m_ channel, the sum over the harmonics in
// use of amplitude times cos(2*pi*(k+1)*frequency*time + phase), as a signed Q.12
// value rounded half up. Both channels use valid and ready.
// The pipeline has 11 register stages: two phase stages (the 32 by 32
// frequency-time multiply, then the per-harmonic phase and quadrant fold), seven
// cosine stages (the squaring, the polynomial multiplies, then rounding and
// sign), and two output stages (amplitude products, then the sum and rounding).
// Throughput is one word per cycle while the receiver does not stall; no stage
// holds more than one multiply per harmonic, and all harmonics run side by side.
// Configuration is written through cfg_wen, cfg_index and cfg_wdata while the block
// is idle; an index beyond the register list is ignored.
// Reset clears all stage valid bits and loads the register defaults: frequency 1.0,
// a unit fundamental amplitude, zero phases and one harmonic.
// When the receiver stalls, each stage holds its word; bubbles close up, so s_ready
// stays high until every stage holds a word, and no word is lost or repeated.
module fourier_series_synthesizer_top import fss_pkg::*; (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [TIME_W-1:0]          s_time_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [RESULT_W-1:0] m_boundary_value,
    input  logic                       cfg_wen,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

    logic [FREQ_W-1:0]  frequency_reg;
    logic [TABLE_W-1:0] amplitude_reg;
    logic [TABLE_W-1:0] phase_reg;
    logic [COUNT_W-1:0] count_reg;
    cfg_t               cfg;

    // Handshakes between the three pipeline sections.
    logic ph_valid, ph_ready;
    logic cs_valid, cs_ready;
    mag_t ph_mag [HARMONICS];
    logic ph_neg [HARMONICS];
    cos_t cs_cos [HARMONICS];

    // Register writes keep only the bits each register holds.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frequency_reg <= FREQ_RESET;
            amplitude_reg <= AMP_RESET;
            phase_reg     <= PHASE_RESET;
            count_reg     <= COUNT_RESET;
        end else if (cfg_wen) begin
            case (cfg_index)
                CFG_FREQUENCY: frequency_reg <= cfg_wdata[FREQ_W-1:0];
                CFG_AMPLITUDE: amplitude_reg <= cfg_wdata[TABLE_W-1:0];
                CFG_PHASE:     phase_reg     <= cfg_wdata[TABLE_W-1:0];
                CFG_COUNT:     count_reg     <= cfg_wdata[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.frequency = frequency_reg;
    assign cfg.amplitude = amplitude_reg;
    assign cfg.phase     = phase_reg;
    assign cfg.count     = count_reg;

    fss_phase u_phase (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_time   (s_time_value),
        .out_valid (ph_valid),
        .out_ready (ph_ready),
        .out_mag   (ph_mag),
        .out_neg   (ph_neg)
    );

    fss_cosine u_cosine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (ph_valid),
        .in_ready  (ph_ready),
        .in_mag    (ph_mag),
        .in_neg    (ph_neg),
        .out_valid (cs_valid),
        .out_ready (cs_ready),
        .out_cos   (cs_cos)
    );

    fss_accum u_accum (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (cs_valid),
        .in_ready  (cs_ready),
        .in_cos    (cs_cos),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_value (m_boundary_value)
    );

endmodule

// ===== sim/boundary_value_checker.sv =====
// Checker that predicts and compares every boundary value word of the synthesizer.
module boundary_value_checker
    import fss_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [TIME_W-1:0]          s_time_value,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic signed [RESULT_W-1:0] m_boundary_value,
    input  logic                       cfg_wen,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                       run_done,
    output int                         mismatches,
    output int                         in_flight,
    output int                         results_checked
);

    // Odd polynomial for sin(pi/2 * x), unsigned Q.30, highest order last.
    localparam logic [63:0] SIN_K1 = 64'd1686629713;
    localparam logic [63:0] SIN_K3 = 64'd693598668;
    localparam logic [63:0] SIN_K5 = 64'd85569306;
    localparam logic [63:0] SIN_K7 = 64'd5026995;
    localparam logic [63:0] SIN_K9 = 64'd172272;
    localparam logic [14:0] QUARTER = 15'd16384;

    typedef struct {
        logic [TIME_W-1:0]   sample_time;
        logic [RESULT_W-1:0] value;
    } boundary_due_t;

    logic [FREQ_W-1:0]  freq_reg;
    logic [TABLE_W-1:0] amp_reg;
    logic [TABLE_W-1:0] phase_reg;
    logic [COUNT_W-1:0] count_reg;
    boundary_due_t      pending_boundaries[$];
    boundary_due_t      due;
    logic               leftovers_done;

    // sin(pi/2 * m/16384) in Q1.15, clipped at 32767.
    function automatic int quarter_sine(input logic [14:0] m);
        logic [63:0] x, x2, acc, q15;
        x   = {33'd0, m, 16'd0};
        x2  = (x * x) >> 30;
        acc = SIN_K7 - ((x2 * SIN_K9) >> 30);
        acc = SIN_K5 - ((x2 * acc) >> 30);
        acc = SIN_K3 - ((x2 * acc) >> 30);
        acc = SIN_K1 - ((x2 * acc) >> 30);
        q15 = (((x * acc) >> 30) + 64'd16384) >> 15;
        if (q15 > 64'd32767) begin
            q15 = 64'd32767;
        end
        return int'(q15);
    endfunction

    function automatic int turn_cosine(input logic [15:0] p);
        logic [14:0] rest, fold;
        rest = {1'b0, p[13:0]};
        fold = QUARTER - rest;
        case (p[15:14])
            2'd0:    return quarter_sine(fold);
            2'd1:    return -quarter_sine(rest);
            2'd2:    return -quarter_sine(fold);
            default: return quarter_sine(rest);
        endcase
    endfunction

    // Sum of the harmonic terms for one time sample, rounded half up to Q.12.
    function automatic logic [RESULT_W-1:0] predict_boundary(input logic [TIME_W-1:0] t);
        logic [63:0]        prod, frac;
        logic [15:0]        ph;
        logic signed [15:0] amp;
        logic [COUNT_W-1:0] terms;
        longint             acc;
        acc   = 0;
        prod  = 64'(freq_reg) * 64'(t);
        terms = (count_reg > COUNT_W'(HARMONICS)) ? COUNT_W'(HARMONICS) : count_reg;
        for (int k = 0; k < HARMONICS; k++) begin
            if (k < int'(terms)) begin
                frac = (prod * 64'(k + 1)) & 64'hFFFF_FFFF;
                ph   = 16'((frac + 64'd32768) >> 16);
                ph   = ph + phase_reg[16*k +: 16];
                amp  = amp_reg[16*k +: 16];
                acc  = acc + longint'(amp) * longint'(turn_cosine(ph));
            end
        end
        acc = acc + 64'sd16384;
        return RESULT_W'(acc >>> 15);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            freq_reg  = 32'd65536;
            amp_reg   = 64'd4096;
            phase_reg = 64'd0;
            count_reg = 3'd1;
            pending_boundaries.delete();
            leftovers_done = 1'b0;
        end else begin
            if (cfg_wen) begin
                case (cfg_index)
                    CFG_FREQUENCY: freq_reg  = cfg_wdata[FREQ_W-1:0];
                    CFG_AMPLITUDE: amp_reg   = cfg_wdata[TABLE_W-1:0];
                    CFG_PHASE:     phase_reg = cfg_wdata[TABLE_W-1:0];
                    CFG_COUNT:     count_reg = cfg_wdata[COUNT_W-1:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                if (pending_boundaries.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected boundary_value word: expected none, got %0d",
                             $time, m_boundary_value);
                end else begin
                    due = pending_boundaries.pop_front();
                    results_checked++;
                    if (m_boundary_value !== due.value) begin
                        mismatches++;
                        $display("%0t: boundary_value for time %h: expected %0d, got %0d",
                                 $time, due.sample_time, $signed(due.value),
                                 m_boundary_value);
                    end
                end
            end
            if (s_valid && s_ready) begin
                due.sample_time = s_time_value;
                due.value       = predict_boundary(s_time_value);
                pending_boundaries.push_back(due);
            end
            if (run_done && !leftovers_done) begin
                leftovers_done = 1'b1;
                if (pending_boundaries.size() != 0) begin
                    mismatches += pending_boundaries.size();
                    $display("%0t: boundary_value words missing: expected %0d more, got 0",
                             $time, pending_boundaries.size());
                end
            end
        end
        in_flight = pending_boundaries.size();
    end

endmodule

// ===== sim/tb_top.sv =====
// Testbench top for the Fourier series synthesizer: stimulus, register setup and verdict.
module tb_top;
    import fss_pkg::*;

    // The pipeline is short, so a short drain is plenty; the cycle
    // limit covers roughly 1070 words at worst-case stalls many times over.
    localparam int CYCLE_LIMIT       = 300000;
    localparam int DRAIN_CYCLES      = 24;
    localparam int SEGMENT_SAMPLES   = 70;
    localparam int SEGMENTS_PER_MODE = 5;
    localparam int IDLE_MODES        = 3;

    // Register indexes past the end of the list; writes there must be ignored.
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_FIRST = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LAST  = 3'd7;

    logic                       aclk             = 1'b0;
    logic                       aresetn          = 1'b0;
    logic                       s_valid          = 1'b0;
    logic                       s_ready;
    logic [TIME_W-1:0]          s_time_value     = '0;
    logic                       m_valid;
    logic                       m_ready          = 1'b0;
    logic signed [RESULT_W-1:0] m_boundary_value;
    logic                       cfg_wen          = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index        = '0;
    logic [CFG_DATA_W-1:0]      cfg_wdata        = '0;
    logic                       run_done         = 1'b0;
    logic                       s_fire           = 1'b0;

    int mismatches;
    int in_flight;
    int results_checked;
    int cycle_count     = 0;
    int samples_sent    = 0;
    int settings_used   = 0;
    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    fourier_series_synthesizer_top dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_time_value     (s_time_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_boundary_value (m_boundary_value),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    boundary_value_checker checker_i (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_time_value     (s_time_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_boundary_value (m_boundary_value),
        .cfg_wen          (cfg_wen),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .run_done         (run_done),
        .mismatches       (mismatches),
        .in_flight        (in_flight),
        .results_checked  (results_checked)
    );

    // Record each input handshake at the rising edge so that the sender can see
    // at the next falling edge whether its word was taken, free of races.
    always @(posedge aclk) begin
        s_fire <= s_valid && s_ready;
    end

    // The receiver stalls at random, at the rate the current idle mix asks for.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_top failed");
            $finish;
        end
    end

    // One register write: enable high for one rising edge, then low again. The
    // second wait keeps back-to-back writes from raising and lowering the enable
    // in the same time step.
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] data);
        cfg_wen   <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(negedge aclk);
        cfg_wen   <= 1'b0;
        @(negedge aclk);
    endtask

    // Offer one time sample. The sender may idle first; once valid is up it stays
    // up, with the word unchanged, until the handshake has happened. Valid is
    // left high afterwards so that the next word can follow without a gap.
    task automatic send_sample(input logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_time_value <= t;
        do @(negedge aclk); while (!s_fire);
        samples_sent++;
    endtask

    // Drop valid and wait until every predicted word has come back. Every sample
    // produces a word, so nothing is still in the pipeline once this returns.
    task automatic wait_until_idle();
        s_valid <= 1'b0;
        do @(negedge aclk); while (in_flight != 0);
    endtask

    function automatic logic [TIME_W-1:0] random_time();
        case ($urandom_range(5))
            0:       return TIME_W'($urandom_range(0, 65535));
            1:       return {16'hFFFF, 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] random_lane();
        case ($urandom_range(5))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // A fresh random setting for all four registers. Frequency and count are
    // always written with junk above their width, and now and then a write to a
    // spare index is thrown in to show that it changes nothing.
    task automatic load_random_settings();
        logic [FREQ_W-1:0]  freq;
        logic [TABLE_W-1:0] amps;
        logic [COUNT_W-1:0] count;
        case ($urandom_range(6))
            0:       freq = 32'd0;
            1:       freq = 32'hFFFF_FFFF;
            2:       freq = 32'd65536;
            3:       freq = FREQ_W'($urandom_range(1, 32'h0010_0000));
            default: freq = $urandom;
        endcase
        for (int k = 0; k < HARMONICS; k++) begin
            amps[16*k +: 16] = random_lane();
        end
        if ($urandom_range(9) < 7) begin
            count = COUNT_W'($urandom_range(1, HARMONICS));
        end else begin
            count = COUNT_W'($urandom_range(0, 7));
        end
        write_reg(CFG_FREQUENCY, {$urandom, freq});
        write_reg(CFG_AMPLITUDE, amps);
        write_reg(CFG_PHASE, {$urandom, $urandom});
        write_reg(CFG_COUNT, {$urandom, 29'($urandom), count});
        if ($urandom_range(3) == 0) begin
            write_reg(CFG_INDEX_W'($urandom_range(CFG_SPARE_FIRST, CFG_SPARE_LAST)),
                      {$urandom, $urandom});
        end
        settings_used++;
    endtask

    initial begin
        // Reset is held low from the start and then released for good.
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, first with the reset settings: unit fundamental, so the
        // quarter turns land exactly on the cosine's peaks and zeros.
        settings_used = 1;
        send_sample(32'h0000_0000);
        send_sample(32'h0000_4000);
        send_sample(32'h0000_8000);
        send_sample(32'h0000_C000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0000_2000);

        // A harmonic count of zero sums nothing. The write carries set bits above
        // the register's width, which the block has to drop.
        wait_until_idle();
        write_reg(CFG_COUNT, 64'hFFFF_FFFF_FFFF_FFF8);
        settings_used++;
        send_sample(32'h1234_5678);
        send_sample(32'h0000_8000);

        // Full-scale frequency, extreme amplitudes of both signs, phase offsets
        // on and beside the quadrant borders, and a count of seven that saturates at four.
        wait_until_idle();
        write_reg(CFG_FREQUENCY, 64'hABCD_0000_FFFF_FFFF);
        write_reg(CFG_AMPLITUDE, 64'h8000_7FFF_8000_7FFF);
        write_reg(CFG_PHASE, 64'h4000_C000_8000_FFFF);
        write_reg(CFG_COUNT, 64'd7);
        settings_used++;
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);
        send_sample(32'h0001_0000);
        send_sample(32'h8000_0001);

        // Largest negative sum: all lanes at the most negative amplitude and the
        // cosine at its peak. The spare-index write must leave all of this alone.
        wait_until_idle();
        write_reg(CFG_FREQUENCY, 64'd0);
        write_reg(CFG_AMPLITUDE, 64'h8000_8000_8000_8000);
        write_reg(CFG_PHASE, 64'd0);
        write_reg(CFG_COUNT, 64'd4);
        write_reg(CFG_SPARE_FIRST, 64'h0123_4567_89AB_CDEF);
        settings_used++;
        send_sample(32'h0000_0000);
        send_sample(32'hFFFF_FFFF);

        // Largest positive sum: half-turn offsets flip every cosine; a count of
        // five saturates as well.
        wait_until_idle();
        write_reg(CFG_PHASE, 64'h8000_8000_8000_8000);
        write_reg(CFG_COUNT, 64'd5);
        write_reg(CFG_SPARE_LAST, 64'hFFFF_FFFF_FFFF_FFFF);
        settings_used++;
        send_sample($urandom);
        send_sample($urandom);

        // Random part, in three idle mixes. Settings change only when the block
        // is idle; in every other segment the sender also pauses halfway until
        // all outstanding words have been returned.
        for (int mode = 0; mode < IDLE_MODES; mode++) begin
            for (int seg = 0; seg < SEGMENTS_PER_MODE; seg++) begin
                wait_until_idle();
                case (mode)
                    0: begin
                        send_idle_pct = 21;
                        recv_idle_pct = 65;
                    end
                    1: begin
                        send_idle_pct = 65;
                        recv_idle_pct = 21;
                    end
                    default: begin
                        send_idle_pct = 0;
                        recv_idle_pct = 0;
                    end
                endcase
                load_random_settings();
                for (int i = 0; i < SEGMENT_SAMPLES; i++) begin
                    if (seg % 2 == 0 && i == SEGMENT_SAMPLES / 2) begin
                        wait_until_idle();
                    end
                    send_sample(random_time());
                end
            end
        end

        // Let the pipeline run dry, wait out the drain so that any stray word can
        // show, then have the checker count what is still outstanding.
        wait_until_idle();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        run_done <= 1'b1;
        repeat (2) @(negedge aclk);

        $display("Run covered %0d time samples across %0d register settings; %0d words checked.",
                 samples_sent, settings_used, results_checked);
        $display("Idle mixes: sender-heavy, receiver-heavy and none, with mid-run pauses.");
        if (mismatches == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
